### sv/pwf_pkg.sv
// Shared types and constants for the PSF-weighted flux block.
// No dependencies; used by all pwf_* modules and psf_weighted_flux.
`timescale 1ns / 1ps
`default_nettype none
package pwf_pkg;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_CLIPPED = 2'd1;
    localparam logic [1:0] ST_ZERO_WE = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    // field widths
    localparam int IMG_W  = 24;
    localparam int VAR_W  = 24;
    localparam int WGT_W  = 18;
    localparam int RES_W  = 40;

    // sums of one footprint, handed from the accumulator to the solver
    typedef struct packed {
        logic [63:0] swi;     // sum w*image, signed Q.16
        logic [63:0] swwv;    // sum w*w*variance, Q.32
        logic [31:0] sw;      // sum w, signed Q.16
        logic [47:0] sww;     // sum w*w, Q.32
        logic        clipped; // some pixel outside the image
    } t_snap;

endpackage
`default_nettype wire

### sv/pwf_front.sv
// Front part: three-stage multiply pipeline and the four running sums.
// Depends on pwf_pkg; pushes one t_snap per footprint into the queue.
`timescale 1ns / 1ps
`default_nettype none
module pwf_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic signed [pwf_pkg::IMG_W-1:0] i_image,
    input  wire logic        [pwf_pkg::VAR_W-1:0] i_var,
    input  wire logic signed [pwf_pkg::WGT_W-1:0] i_weight,
    input  wire logic                        i_inside,
    input  wire logic                        i_last,
    input  wire logic                        i_full,
    output logic                             o_push,
    output pwf_pkg::t_snap                   o_snap
);
    // stage 1: captured pixel
    logic                 r_v1, r_in1, r_last1;
    logic signed [23:0]   r_img1;
    logic        [23:0]   r_var1;
    logic signed [17:0]   r_w1;
    // stage 2: w*image and w*w
    logic                 r_v2, r_in2, r_last2;
    logic signed [41:0]   r_wi2;
    logic        [35:0]   r_ww2;
    logic        [23:0]   r_var2;
    logic signed [17:0]   r_w2;
    // stage 3: w*w*variance
    logic                 r_v3, r_in3, r_last3;
    logic signed [41:0]   r_wi3;
    logic        [35:0]   r_ww3;
    logic        [59:0]   r_wwv3;
    logic signed [17:0]   r_w3;
    // sums
    logic [63:0] r_swi, r_swwv, n_swi, n_swwv;
    logic [31:0] r_sw, n_sw;
    logic [47:0] r_sww, n_sww;
    logic        r_clip, n_clip;
    logic        w_en;
    logic signed [35:0] w_wwprod;

    // whole pipeline holds while a finished footprint cannot enter the queue
    assign w_en     = !(r_v3 && r_last3 && i_full);
    assign o_ready  = w_en;
    assign w_wwprod = r_w1 * r_w1;

    // valid and flag bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in1   <= i_inside;
            r_last1 <= i_last;
            r_img1  <= i_image;
            r_var1  <= i_var;
            r_w1    <= i_weight;
            r_in2   <= r_in1;
            r_last2 <= r_last1;
            r_wi2   <= r_w1 * r_img1;
            r_ww2   <= w_wwprod[35:0];
            r_var2  <= r_var1;
            r_w2    <= r_w1;
            r_in3   <= r_in2;
            r_last3 <= r_last2;
            r_wi3   <= r_wi2;
            r_ww3   <= r_ww2;
            r_wwv3  <= r_ww2 * r_var2;
            r_w3    <= r_w2;
        end
    end

    // next sums including the stage 3 pixel
    always_comb begin
        n_sw   = r_sw + {{14{r_w3[17]}}, r_w3};
        n_sww  = r_sww + {12'd0, r_ww3};
        n_swi  = r_swi;
        n_swwv = r_swwv;
        n_clip = r_clip;
        if (r_in3) begin
            n_swi  = r_swi + {{22{r_wi3[41]}}, r_wi3};
            n_swwv = r_swwv + {4'd0, r_wwv3};
        end else begin
            n_clip = 1'b1;
        end
    end

    assign o_push         = r_v3 && r_last3 && w_en;
    assign o_snap.swi     = n_swi;
    assign o_snap.swwv    = n_swwv;
    assign o_snap.sw      = n_sw;
    assign o_snap.sww     = n_sww;
    assign o_snap.clipped = n_clip;

    // accumulate, clear after the last pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swi  <= '0;
            r_swwv <= '0;
            r_sw   <= '0;
            r_sww  <= '0;
            r_clip <= 1'b0;
        end else if (r_v3 && w_en) begin
            if (r_last3) begin
                r_swi  <= '0;
                r_swwv <= '0;
                r_sw   <= '0;
                r_sww  <= '0;
                r_clip <= 1'b0;
            end else begin
                r_swi  <= n_swi;
                r_swwv <= n_swwv;
                r_sw   <= n_sw;
                r_sww  <= n_sww;
                r_clip <= n_clip;
            end
        end
    end
endmodule
`default_nettype wire

### sv/pwf_queue.sv
// Small FIFO of footprint sums between the accumulator and the solver.
// Depends on pwf_pkg for the t_snap entry type.
`timescale 1ns / 1ps
`default_nettype none
module pwf_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  pwf_pkg::t_snap      i_data,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output pwf_pkg::t_snap      o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    pwf_pkg::t_snap r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule
`default_nettype wire

### sv/pwf_back.sv
// Back part: sequencer with split multiplies, a shared bit-serial divider
// and a digit-serial square root; holds the result in an output register.
// Depends on pwf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pwf_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  pwf_pkg::t_snap    i_snap,
    output logic              o_pop,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [39:0]       o_flux,
    output logic [39:0]       o_err,
    output logic [1:0]        o_status
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MULA = 4'd1;
    localparam logic [3:0] S_MULB = 4'd2;
    localparam logic [3:0] S_DIVF = 4'd3;
    localparam logic [3:0] S_SQRT = 4'd4;
    localparam logic [3:0] S_MULC = 4'd5;
    localparam logic [3:0] S_MULD = 4'd6;
    localparam logic [3:0] S_DIVE = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    localparam logic [103:0] NEG_LIM = 104'h80_0000_0000;
    localparam logic [103:0] POS_LIM = 104'h7F_FFFF_FFFF;

    logic [3:0]   r_st;
    logic [63:0]  r_wimag;
    logic [31:0]  r_swmag;
    logic         r_neg, r_sat;
    logic [47:0]  r_den, r_rem;
    logic [103:0] r_num;
    logic [95:0]  r_prod;
    logic [6:0]   r_cnt;
    logic [79:0]  r_rad;
    logic [39:0]  r_root;
    logic [41:0]  r_srem;
    logic [39:0]  r_flux, r_errv;
    logic [1:0]   r_stat;
    logic         r_ov;
    logic [39:0]  r_oflux, r_oerr;
    logic [1:0]   r_ostat;

    // divider step
    logic [48:0]  w_rem2;
    logic         w_ge;
    logic [48:0]  w_sub;
    // root step
    logic [43:0]  w_rr, w_t, w_rsub;
    logic         w_rge;
    logic [63:0]  w_wimag;
    logic [31:0]  w_swmag;
    logic [39:0]  w_qmag;
    // partial products
    logic [63:0]  w_pa, w_pb;
    logic [51:0]  w_pc, w_pd;

    assign w_rem2 = {r_rem, r_num[103]};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});
    assign w_sub  = w_rem2 - {1'b0, r_den};
    assign w_rr   = {r_srem, r_rad[79:78]};
    assign w_t    = {2'd0, r_root, 2'b01};
    assign w_rge  = (w_rr >= w_t);
    assign w_rsub = w_rr - w_t;
    assign w_wimag = i_snap.swi[63] ? 64'd0 - i_snap.swi : i_snap.swi;
    assign w_swmag = i_snap.sw[31] ? 32'd0 - i_snap.sw : i_snap.sw;
    assign w_pa    = r_wimag[31:0] * r_swmag;
    assign w_pb    = r_wimag[63:32] * r_swmag;
    assign w_pc    = r_root[19:0] * r_swmag;
    assign w_pd    = r_root[39:20] * r_swmag;
    // clamped flux magnitude from the quotient
    assign w_qmag = (r_neg && (r_num > NEG_LIM)) ? NEG_LIM[39:0] :
                    (!r_neg && (r_num > POS_LIM)) ? POS_LIM[39:0] : r_num[39:0];

    assign o_pop    = (r_st == S_IDLE) && i_valid;
    assign o_valid  = r_ov;
    assign o_flux   = r_oflux;
    assign o_err    = r_oerr;
    assign o_status = r_ostat;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            if (r_ov && i_ready && (r_st != S_DONE)) begin
                r_ov <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_wimag <= w_wimag;
                        r_swmag <= w_swmag;
                        r_neg   <= i_snap.swi[63] ^ i_snap.sw[31];
                        r_den   <= i_snap.sww;
                        r_rad   <= {i_snap.swwv, 16'd0};
                        r_sat   <= 1'b0;
                        r_flux  <= '0;
                        r_errv  <= '0;
                        if (i_snap.clipped) begin
                            r_stat <= pwf_pkg::ST_CLIPPED;
                            r_st   <= S_DONE;
                        end else if (i_snap.sww == '0) begin
                            r_stat <= pwf_pkg::ST_ZERO_WE;
                            r_st   <= S_DONE;
                        end else begin
                            r_stat <= pwf_pkg::ST_OK;
                            r_st   <= S_MULA;
                        end
                    end
                end
                S_MULA: begin
                    r_prod <= {32'd0, w_pa};
                    r_st   <= S_MULB;
                end
                S_MULB: begin
                    r_num  <= {r_prod + {w_pb, 32'd0}, 8'd0};
                    r_rem  <= '0;
                    r_cnt  <= 7'd104;
                    r_st   <= S_DIVF;
                end
                S_DIVF, S_DIVE: begin
                    if (r_cnt != '0) begin
                        r_rem <= w_ge ? w_sub[47:0] : w_rem2[47:0];
                        r_num <= {r_num[102:0], w_ge};
                        r_cnt <= r_cnt - 1'b1;
                    end else if (r_st == S_DIVF) begin
                        // a zero quotient is never negative
                        r_flux <= (r_neg && r_num != '0) ? 40'd0 - w_qmag : w_qmag;
                        r_sat  <= (r_neg && r_num > NEG_LIM) || (!r_neg && r_num > POS_LIM);
                        r_root <= '0;
                        r_srem <= '0;
                        r_cnt  <= 7'd40;
                        r_st   <= S_SQRT;
                    end else begin
                        if (|r_num[103:40]) begin
                            r_errv <= '1;
                            r_stat <= pwf_pkg::ST_SAT;
                        end else begin
                            r_errv <= r_num[39:0];
                            r_stat <= r_sat ? pwf_pkg::ST_SAT : pwf_pkg::ST_OK;
                        end
                        r_st <= S_DONE;
                    end
                end
                S_SQRT: begin
                    if (r_cnt != '0) begin
                        r_srem <= w_rge ? w_rsub[41:0] : w_rr[41:0];
                        r_root <= {r_root[38:0], w_rge};
                        r_rad  <= {r_rad[77:0], 2'b00};
                        r_cnt  <= r_cnt - 1'b1;
                    end else begin
                        r_st <= S_MULC;
                    end
                end
                S_MULC: begin
                    r_prod <= {44'd0, w_pc};
                    r_st   <= S_MULD;
                end
                S_MULD: begin
                    r_num <= {8'd0, r_prod + {24'd0, w_pd, 20'd0}};
                    r_rem <= '0;
                    r_cnt <= 7'd104;
                    r_st  <= S_DIVE;
                end
                S_DONE: begin
                    if (!r_ov || i_ready) begin
                        r_ov    <= 1'b1;
                        r_oflux <= r_flux;
                        r_oerr  <= r_errv;
                        r_ostat <= r_stat;
                        r_st    <= S_IDLE;
                    end
                end
                default: begin
                    r_st <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### sv/psf_weighted_flux.sv
// PSF-weighted flux: one pixel per cycle in, one result per footprint out.
// Front pipeline: registered multiplies feed the sums; accepts a pixel every cycle
// unless a finished footprint waits for a free queue entry.
// Solver: one footprint at a time (two 104-step divides, a 40-step root,
// four multiply steps, pop and output); a 4-entry queue buffers footprints.
// Synchronous active-low reset clears sums, queue and sequencer.
`timescale 1ns / 1ps
`default_nettype none
module psf_weighted_flux #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // image_value, variance_value, weight_value
    input  wire logic [0:0]  s_axis_tuser,  // inside_image
    input  wire logic        s_axis_tlast,  // last_pixel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [79:0]      m_axis_tdata,  // flux, flux_error
    output logic [1:0]       m_axis_tuser   // status
);
    pwf_pkg::t_snap w_push_d, w_pop_d;
    logic w_push, w_full, w_qv, w_pop;
    logic [39:0] w_flux, w_err;

    pwf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_image  (s_axis_tdata[23:0]),
        .i_var    (s_axis_tdata[47:24]),
        .i_weight (s_axis_tdata[65:48]),
        .i_inside (s_axis_tuser[0]),
        .i_last   (s_axis_tlast),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_snap   (w_push_d)
    );

    pwf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_d),
        .o_full  (w_full),
        .o_valid (w_qv),
        .i_pop   (w_pop),
        .o_data  (w_pop_d)
    );

    pwf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_qv),
        .i_snap   (w_pop_d),
        .o_pop    (w_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_flux   (w_flux),
        .o_err    (w_err),
        .o_status (m_axis_tuser)
    );

    assign m_axis_tdata = {w_err, w_flux};

`ifndef SYNTHESIS
    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push) else $error("queue overflow");

    // clipped or zero-energy footprints carry no measurement
    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == pwf_pkg::ST_CLIPPED ||
                           m_axis_tuser == pwf_pkg::ST_ZERO_WE)) |-> (m_axis_tdata == '0))
        else $error("flags with nonzero result");

    // the solver pops only what the queue holds
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qv) else $error("pop from empty queue");
`endif
endmodule
`default_nettype wire

### tb/sv/pwf_flux_checker.sv
// Checker for psf_weighted_flux: watches both stream channels, predicts each
// footprint result bit for bit and compares it. Depends on pwf_pkg.
`timescale 1ns / 1ps
module pwf_flux_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [71:0] i_in_data,  // image_value, variance_value, weight_value
    input  wire logic [0:0]  i_in_user,  // inside_image
    input  wire logic        i_in_last,  // last_pixel
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [79:0] i_out_data, // flux, flux_error
    input  wire logic [1:0]  i_out_user, // status
    output int               o_errors,
    output int               o_pending
);
    typedef struct packed {
        logic [39:0] flux;
        logic [39:0] flux_error;
        logic [1:0]  status;
    } t_result;

    t_result result_q[$];

    // running sums of the current footprint
    logic [63:0] acc_wi;
    logic [63:0] acc_wwv;
    logic [31:0] acc_w;
    logic [47:0] acc_ww;
    logic        acc_clip;

    // integer square root, floor
    function automatic logic [63:0] isqrt128(input logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = 128'(c) * 128'(c);
            if (sq <= n) r = c;
        end
        return r;
    endfunction

    // close the footprint: produce flux, error and status from the sums
    function automatic t_result solve_footprint();
        t_result     r;
        logic [63:0] sw_mag;
        logic [63:0] wi_mag;
        logic        neg;
        logic [135:0] q;
        logic [127:0] e;
        logic [63:0] root;
        r = '0;
        r.status = pwf_pkg::ST_OK;
        if (acc_clip) begin
            r.status = pwf_pkg::ST_CLIPPED;
        end else if (acc_ww == 0) begin
            r.status = pwf_pkg::ST_ZERO_WE;
        end else begin
            sw_mag = {32'd0, (acc_w[31] ? (~acc_w + 32'd1) : acc_w)};
            wi_mag = acc_wi[63] ? -acc_wi : acc_wi;
            neg = acc_wi[63] != acc_w[31];
            q = ((136'(wi_mag) * 136'(sw_mag)) << 8) / 136'(acc_ww);
            q = q & {8'd0, {128{1'b1}}};  // the quotient keeps 128 bits
            if (q == 0) neg = 1'b0;
            if (neg) begin
                if (q > 136'h80_0000_0000) begin
                    q = 136'h80_0000_0000;
                    r.status = pwf_pkg::ST_SAT;
                end
                r.flux = -q[39:0];
            end else begin
                if (q > 136'h7F_FFFF_FFFF) begin
                    q = 136'h7F_FFFF_FFFF;
                    r.status = pwf_pkg::ST_SAT;
                end
                r.flux = q[39:0];
            end
            root = isqrt128({48'd0, acc_wwv, 16'd0});
            e = (128'(root) * 128'(sw_mag)) / 128'(acc_ww);
            if (e > 128'hFF_FFFF_FFFF) begin
                r.flux_error = '1;
                r.status = pwf_pkg::ST_SAT;
            end else begin
                r.flux_error = e[39:0];
            end
        end
        return r;
    endfunction

    // input side: accumulate and predict
    always @(posedge i_clk) begin
        logic signed [23:0] img;
        logic [23:0]        var_v;
        logic signed [17:0] w;
        logic [63:0]        ww;
        img   = i_in_data[23:0];
        var_v = i_in_data[47:24];
        w     = i_in_data[65:48];
        ww    = 64'($signed(w) * $signed(w));
        if (!i_rst_n) begin
            acc_wi = '0; acc_wwv = '0; acc_w = '0; acc_ww = '0; acc_clip = 1'b0;
            result_q.delete();
        end else if (i_in_valid && i_in_ready) begin
            acc_w  = acc_w + 32'($signed(w));
            acc_ww = acc_ww + ww[47:0];
            if (i_in_user[0]) begin
                acc_wi  = acc_wi + 64'($signed(w) * $signed(img));
                acc_wwv = acc_wwv + ww * 64'(var_v);
            end else begin
                acc_clip = 1'b1;
            end
            if (i_in_last) begin
                result_q.push_back(solve_footprint());
                acc_wi = '0; acc_wwv = '0; acc_w = '0; acc_ww = '0; acc_clip = 1'b0;
            end
        end
    end

    // output side: compare with the oldest prediction
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            if (result_q.size() == 0) begin
                $error("unexpected result flux=%h err=%h status=%0d",
                       i_out_data[39:0], i_out_data[79:40], i_out_user);
                o_errors++;
            end else begin
                exp_r = result_q.pop_front();
                if (i_out_data[39:0] !== exp_r.flux) begin
                    $error("flux: expected %h, got %h", exp_r.flux, i_out_data[39:0]);
                    o_errors++;
                end
                if (i_out_data[79:40] !== exp_r.flux_error) begin
                    $error("flux_error: expected %h, got %h",
                           exp_r.flux_error, i_out_data[79:40]);
                    o_errors++;
                end
                if (i_out_user !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, i_out_user);
                    o_errors++;
                end
            end
        end
    end

    initial o_errors = 0;
    assign o_pending = result_q.size();

endmodule

### tb/sv/tb_psf_weighted_flux.sv
// Top testbench for psf_weighted_flux: drives random and directed footprints
// with random gaps and stalls; checking lives in pwf_flux_checker.
`timescale 1ns / 1ps
module tb_psf_weighted_flux;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [71:0] s_data = '0;  // image_value, variance_value, weight_value
    logic [0:0]  s_user = '0;  // inside_image
    logic        s_last = 1'b0; // last_pixel
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [79:0] m_data;       // flux, flux_error
    logic [1:0]  m_user;       // status
    int          errors;
    int          pending;
    bit          stim_done = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    psf_weighted_flux i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
        .s_axis_tdata(s_data), .s_axis_tuser(s_user), .s_axis_tlast(s_last),
        .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
        .m_axis_tdata(m_data), .m_axis_tuser(m_user)
    );

    pwf_flux_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_valid), .i_in_ready(s_ready), .i_in_data(s_data),
        .i_in_user(s_user), .i_in_last(s_last),
        .i_out_valid(m_valid), .i_out_ready(m_ready), .i_out_data(m_data),
        .i_out_user(m_user), .o_errors(errors), .o_pending(pending)
    );

    // send one pixel after a random gap, hold until accepted
    task automatic send_pixel(input logic [23:0] img, input logic [23:0] var_v,
                              input logic [17:0] w, input bit in_img, input bit last);
        int gap;
        gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            @(negedge i_clk);
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {6'd0, w, var_v, img};
        s_user  <= in_img;
        s_last  <= last;
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        s_valid <= 1'b0;
    endtask

    // one footprint of n pixels; mode picks the value ranges
    task automatic send_footprint(input int n, input int mode, input bit allow_clip);
        logic [23:0] img;
        logic [23:0] var_v;
        logic [17:0] w;
        bit          in_img;
        for (int k = 0; k < n; k++) begin
            img   = 24'($urandom);
            var_v = 24'($urandom);
            w     = 18'($urandom);
            if (mode == 1) begin
                img = 24'($urandom_range(0, 2000)) - 24'd1000;
                var_v = 24'($urandom_range(0, 5000));
                w = 18'($urandom_range(0, 4000)) - 18'd2000;
            end else if (mode == 2) begin
                w = ($urandom & 1) ? 18'h1FFFF : 18'h20000;
                img = ($urandom & 1) ? 24'h7FFFFF : 24'h800000;
            end else if (mode == 3) begin
                w = 18'($urandom_range(0, 2)) - 18'd1;  // tiny weights, huge quotients
            end
            in_img = !(allow_clip && ($urandom_range(0, 15) == 0));
            send_pixel(img, var_v, w, in_img, k == n - 1);
        end
    endtask

    // output stall: random per item, with stall-free stretches
    initial begin
        int stall;
        @(posedge i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            @(negedge i_clk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            m_ready <= 1'b1;
            do @(posedge i_clk); while (!m_valid);
        end
    end

    initial begin
        int sent;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed: field extremes, clipped, zero weight
        send_pixel(24'h7FFFFF, 24'hFFFFFF, 18'h1FFFF, 1'b1, 1'b0);
        send_pixel(24'h800000, 24'h000000, 18'h20000, 1'b1, 1'b1);
        send_pixel(24'h123456, 24'h000100, 18'h10000, 1'b0, 1'b1);      // clipped
        send_pixel(24'h000100, 24'h000100, 18'h00000, 1'b1, 1'b0);
        send_pixel(24'h000200, 24'h000200, 18'h00000, 1'b1, 1'b1);      // zero energy
        send_pixel(24'h7FFFFF, 24'hFFFFFF, 18'h00001, 1'b1, 1'b1);      // unit weight, largest image
        send_pixel(24'h800000, 24'hFFFFFF, 18'h00001, 1'b1, 1'b1);      // unit weight, most negative image
        send_pixel(24'h7FFFFF, 24'h000000, 18'h3FFFF, 1'b1, 1'b1);
        send_pixel(24'h000000, 24'h000000, 18'h10000, 1'b1, 1'b1);      // flux zero
        send_pixel(24'h000064, 24'h000064, 18'h10000, 1'b1, 1'b0);
        send_pixel(24'hFFFF9C, 24'h000064, 18'h30000, 1'b1, 1'b1);      // sw cancels
        send_pixel(24'h000005, 24'h000009, 18'h08000, 1'b1, 1'b0);
        send_pixel(24'h000005, 24'h000009, 18'h08000, 1'b0, 1'b0);
        send_pixel(24'h000005, 24'h000009, 18'h08000, 1'b1, 1'b1);      // clip mid-run
        sent = 14;
        drop_valid();
        // hold off until every result is back
        while (pending != 0) @(posedge i_clk);
        // random footprints, mostly small
        while (sent < 450) begin
            int n;
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
            send_footprint(n, $urandom_range(0, 3), 1'b1);
            sent += n;
        end
        drop_valid();
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
